// ===== hw/rtl/wstat_pkg.sv =====
// Shared sizes, codes and control/status structs of the windowed I/O statistics monitor.
// Used by wstat_ctrl, wstat_dp and the top level; depends on nothing.
package wstat_pkg;

    localparam int RING_DEPTH = 256;
    localparam int FRAC_BITS  = 8;

    localparam int CMD_W    = 2;
    localparam int SIZE_W   = 32;
    localparam int TIME_W   = 32;
    localparam int WIN_W    = 16;
    localparam int STATUS_W = 2;
    localparam int OCNT_W   = 9;
    localparam int STAT_W   = 40;
    localparam int RATE_W   = 16;
    localparam int MEM_W    = SIZE_W + TIME_W;

    localparam int IDX_W  = $clog2(RING_DEPTH);
    localparam int FILL_W = $clog2(RING_DEPTH + 1);
    localparam int ADDR_W = $clog2(2 * RING_DEPTH);

    localparam int SUM_W  = SIZE_W + FILL_W;
    localparam int SQ_W   = 2 * SIZE_W + FILL_W;
    localparam int NSQ_W  = SQ_W + FILL_W;
    localparam int RAD_W  = NSQ_W + 2 * FRAC_BITS;
    localparam int ROOT_W = (RAD_W + 1) / 2;
    localparam int DVD_A  = (SUM_W + FRAC_BITS > ROOT_W) ? SUM_W + FRAC_BITS : ROOT_W;
    localparam int DVD_W  = (DVD_A > FILL_W + FRAC_BITS) ? DVD_A : FILL_W + FRAC_BITS;
    localparam int DVS_W  = (WIN_W > FILL_W) ? WIN_W : FILL_W;

    localparam int MUL_STEPS  = FILL_W;
    localparam int SUB_STEPS  = SUM_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = DVD_W;
    localparam int STEP_MAX   = DIV_STEPS + 1;
    localparam int STEP_W     = $clog2(STEP_MAX + 1);

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_CLEAN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_ZERO_WIN = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

    localparam logic [1:0] DSEL_MEAN = 2'd0;
    localparam logic [1:0] DSEL_RATE = 2'd1;
    localparam logic [1:0] DSEL_DEV  = 2'd2;

    typedef struct packed {
        logic       load;
        logic       add_wr;
        logic       walk_init;
        logic       rd;
        logic       ev;
        logic       clean_fin;
        logic       mul_load;
        logic       mul_sub;
        logic       mul_step;
        logic       sqrt_load;
        logic       sqrt_step;
        logic       div_load;
        logic       div_step;
        logic       div_store;
        logic [1:0] div_sel;
        logic       out_load;
    } wstat_cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0] command;
        logic             win_zero;
        logic             more;
        logic             keep;
        logic             cnt_zero;
        logic             plural;
        logic             out_busy;
    } wstat_sts_t;

endpackage

// ===== hw/rtl/wstat_ctrl.sv =====
// Sequencer of the monitor: decodes a command and steps the datapath through walk,
// multiply, square root and divide phases. Depends on wstat_pkg.
module wstat_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_fire,
    input  wstat_pkg::wstat_sts_t sts,
    output logic                  idle,
    output wstat_pkg::wstat_cmd_t cmd
);
    import wstat_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_ADD   = 4'd2;
    localparam logic [3:0] S_WALK  = 4'd3;
    localparam logic [3:0] S_EVAL  = 4'd4;
    localparam logic [3:0] S_CLFIN = 4'd5;
    localparam logic [3:0] S_FLUSH = 4'd6;
    localparam logic [3:0] S_DIVM  = 4'd7;
    localparam logic [3:0] S_DIVR  = 4'd8;
    localparam logic [3:0] S_MUL   = 4'd9;
    localparam logic [3:0] S_SUB   = 4'd10;
    localparam logic [3:0] S_SQRT  = 4'd11;
    localparam logic [3:0] S_DIVD  = 4'd12;
    localparam logic [3:0] S_OUT   = 4'd13;

    logic [3:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              is_clean;

    assign idle     = (state_reg == S_IDLE);
    assign is_clean = (sts.command == CMD_CLEAN);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg) inside
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                unique case (sts.command)
                    CMD_ADD:   state_next = S_ADD;
                    CMD_CLEAN:
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = sts.win_zero ? S_CLFIN : S_WALK;
                    end
                    CMD_QUERY:
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = sts.win_zero ? S_OUT : S_WALK;
                    end
                    default:   state_next = S_OUT;
                endcase
            end
            S_ADD:
            begin
                cmd.add_wr = 1'b1;
                state_next = S_OUT;
            end
            S_WALK:
            begin
                if (sts.more)
                begin
                    cmd.rd     = 1'b1;
                    state_next = S_EVAL;
                end
                else
                begin
                    state_next = is_clean ? S_CLFIN : S_FLUSH;
                end
            end
            S_EVAL:
            begin
                if (sts.keep)
                begin
                    cmd.ev     = 1'b1;
                    state_next = S_WALK;
                end
                else
                begin
                    state_next = is_clean ? S_CLFIN : S_FLUSH;
                end
            end
            S_CLFIN:
            begin
                cmd.clean_fin = 1'b1;
                state_next    = S_OUT;
            end
            S_FLUSH:
            begin
                step_next  = '0;
                state_next = sts.cnt_zero ? S_OUT : S_DIVM;
            end
            S_DIVM, S_DIVR, S_DIVD:
            begin
                cmd.div_sel = (state_reg == S_DIVM) ? DSEL_MEAN :
                              (state_reg == S_DIVR) ? DSEL_RATE : DSEL_DEV;
                step_next   = step_reg + 1'b1;
                if (step_reg == '0)
                begin
                    cmd.div_load = 1'b1;
                end
                else if (step_reg <= STEP_W'(DIV_STEPS))
                begin
                    cmd.div_step = 1'b1;
                end
                else
                begin
                    cmd.div_store = 1'b1;
                    step_next     = '0;
                    if (state_reg == S_DIVM)
                        state_next = S_DIVR;
                    else if (state_reg == S_DIVR)
                        state_next = sts.plural ? S_MUL : S_OUT;
                    else
                        state_next = S_OUT;
                end
            end
            S_MUL, S_SUB:
            begin
                cmd.mul_sub = (state_reg == S_SUB);
                step_next   = step_reg + 1'b1;
                if (step_reg == '0)
                begin
                    cmd.mul_load = 1'b1;
                end
                else
                begin
                    cmd.mul_step = 1'b1;
                    if (state_reg == S_MUL && step_reg == STEP_W'(MUL_STEPS))
                    begin
                        step_next  = '0;
                        state_next = S_SUB;
                    end
                    else if (state_reg == S_SUB && step_reg == STEP_W'(SUB_STEPS))
                    begin
                        step_next  = '0;
                        state_next = S_SQRT;
                    end
                end
            end
            S_SQRT:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == '0)
                begin
                    cmd.sqrt_load = 1'b1;
                end
                else
                begin
                    cmd.sqrt_step = 1'b1;
                    if (step_reg == STEP_W'(SQRT_STEPS))
                    begin
                        step_next  = '0;
                        state_next = S_DIVD;
                    end
                end
            end
            S_OUT:
            begin
                if (!sts.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

// ===== hw/rtl/wstat_dp.sv =====
// Datapath of the monitor: mark memory, ring pointers, accumulators, serial multiplier,
// square root and divider, and the result register. Depends on wstat_pkg.
module wstat_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  wstat_pkg::wstat_cmd_t          cmd,
    output wstat_pkg::wstat_sts_t          sts,
    input  logic [wstat_pkg::CMD_W-1:0]    in_command,
    input  logic                           in_channel,
    input  logic [wstat_pkg::SIZE_W-1:0]   in_byte_count,
    input  logic [wstat_pkg::TIME_W-1:0]   in_now_seconds,
    input  logic [wstat_pkg::WIN_W-1:0]    in_window_seconds,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [wstat_pkg::STATUS_W-1:0] status,
    output logic [wstat_pkg::OCNT_W-1:0]   marks_held,
    output logic [wstat_pkg::OCNT_W-1:0]   count_in_window,
    output logic [wstat_pkg::OCNT_W-1:0]   removed_count,
    output logic [wstat_pkg::STAT_W-1:0]   mean_bytes,
    output logic [wstat_pkg::STAT_W-1:0]   stddev_bytes,
    output logic [wstat_pkg::RATE_W-1:0]   ops_per_second
);
    import wstat_pkg::*;

    function automatic logic [IDX_W-1:0] wrap_idx(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] r;
        begin
            r = (v >= ADDR_W'(RING_DEPTH)) ? v - ADDR_W'(RING_DEPTH) : v;
            return IDX_W'(r);
        end
    endfunction

    // item
    logic [CMD_W-1:0]  cmd_reg;
    logic              ch_reg;
    logic [SIZE_W-1:0] bytes_reg;
    logic [TIME_W-1:0] now_reg;
    logic [WIN_W-1:0]  win_reg;
    logic              ovf_reg;

    // rings
    logic [IDX_W-1:0]  head_reg [2];
    logic [FILL_W-1:0] fill_reg [2];
    logic [MEM_W-1:0]  mem [2 * RING_DEPTH];
    logic [MEM_W-1:0]  rdata_reg;

    // walk accumulators
    logic [FILL_W-1:0]   cnt_reg;
    logic [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]     sq_reg;
    logic [2*SIZE_W-1:0] prod_reg;
    logic                pend_reg;

    // serial multiplier, square root, divider
    logic [NSQ_W-1:0]    acc_reg, mcand_reg;
    logic [SUM_W-1:0]    mplr_reg;
    logic [2*ROOT_W-1:0] rad_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [DVD_W-1:0]    dvd_reg;
    logic [DVS_W-1:0]    drem_reg, dvs_reg;

    logic [STAT_W-1:0] mean_reg, dev_reg;
    logic [RATE_W-1:0] rate_reg;
    logic              out_valid_reg;

    logic [IDX_W-1:0]  head_c;
    logic [FILL_W-1:0] fill_c, off_c, removed_c;
    logic              full_c;
    logic [IDX_W-1:0]  rslot_c, wslot_c;
    logic [ADDR_W-1:0] raddr_c, waddr_c;
    logic [TIME_W-1:0] mt_c, age_c;
    logic [SIZE_W-1:0] ms_c;
    logic [ROOT_W+3:0] rem_t_c, trial_c;
    logic [DVS_W:0]    drs_c;
    logic              dge_c;

    assign head_c  = head_reg[ch_reg];
    assign fill_c  = fill_reg[ch_reg];
    assign full_c  = (fill_c == FILL_W'(RING_DEPTH));
    assign off_c   = (cmd_reg == CMD_CLEAN) ? cnt_reg : fill_c - cnt_reg - 1'b1;
    assign rslot_c = wrap_idx(ADDR_W'(head_c) + ADDR_W'(off_c));
    assign wslot_c = full_c ? head_c : wrap_idx(ADDR_W'(head_c) + ADDR_W'(fill_c));
    assign raddr_c = ch_reg ? ADDR_W'(rslot_c) + ADDR_W'(RING_DEPTH) : ADDR_W'(rslot_c);
    assign waddr_c = ch_reg ? ADDR_W'(wslot_c) + ADDR_W'(RING_DEPTH) : ADDR_W'(wslot_c);

    assign mt_c  = rdata_reg[MEM_W-1:SIZE_W];
    assign ms_c  = rdata_reg[SIZE_W-1:0];
    // a mark stamped in the future counts as age zero
    assign age_c = (now_reg >= mt_c) ? now_reg - mt_c : '0;

    assign removed_c = (win_reg == '0) ? fill_c : cnt_reg;

    assign rem_t_c = {rem_reg, rad_reg[2*ROOT_W-1 -: 2]};
    assign trial_c = (ROOT_W + 4)'({root_reg, 2'b01});
    assign drs_c   = {drem_reg, dvd_reg[DVD_W-1]};
    assign dge_c   = (drs_c >= (DVS_W + 1)'(dvs_reg));

    assign sts.command  = cmd_reg;
    assign sts.win_zero = (win_reg == '0);
    assign sts.more     = (cnt_reg < fill_c);
    assign sts.keep     = (cmd_reg == CMD_CLEAN) ? (age_c >= TIME_W'(win_reg))
                                                 : (age_c <= TIME_W'(win_reg));
    assign sts.cnt_zero = (cnt_reg == '0);
    assign sts.plural   = (cnt_reg > FILL_W'(1));
    assign sts.out_busy = out_valid_reg && !out_ready;
    assign out_valid    = out_valid_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.add_wr)
            mem[waddr_c] <= {now_reg, bytes_reg};
        if (cmd.rd)
            rdata_reg <= mem[raddr_c];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg[0]   <= '0;
            head_reg[1]   <= '0;
            fill_reg[0]   <= '0;
            fill_reg[1]   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.add_wr)
            begin
                if (full_c)
                    head_reg[ch_reg] <= wrap_idx(ADDR_W'(head_c) + ADDR_W'(1));
                else
                    fill_reg[ch_reg] <= fill_c + 1'b1;
            end
            if (cmd.clean_fin)
            begin
                head_reg[ch_reg] <= wrap_idx(ADDR_W'(head_c) + ADDR_W'(removed_c));
                fill_reg[ch_reg] <= fill_c - removed_c;
            end
            pend_reg <= cmd.ev && (cmd_reg == CMD_QUERY);
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cmd_reg   <= in_command;
            ch_reg    <= in_channel;
            bytes_reg <= in_byte_count;
            now_reg   <= in_now_seconds;
            win_reg   <= in_window_seconds;
            mean_reg  <= '0;
            dev_reg   <= '0;
            rate_reg  <= '0;
            cnt_reg   <= '0;
        end
        if (cmd.add_wr)
            ovf_reg <= full_c;
        if (cmd.walk_init)
        begin
            cnt_reg <= '0;
            sum_reg <= '0;
            sq_reg  <= '0;
        end
        // square lands in the cycle after the mark is taken
        if (pend_reg)
            sq_reg <= sq_reg + SQ_W'(prod_reg);
        if (cmd.ev)
        begin
            cnt_reg  <= cnt_reg + 1'b1;
            sum_reg  <= sum_reg + SUM_W'(ms_c);
            prod_reg <= ms_c * ms_c;
        end
        if (cmd.clean_fin)
            cnt_reg <= removed_c;

        if (cmd.mul_load)
        begin
            if (cmd.mul_sub)
            begin
                mcand_reg <= NSQ_W'(sum_reg);
                mplr_reg  <= sum_reg;
            end
            else
            begin
                acc_reg   <= '0;
                mcand_reg <= NSQ_W'(sq_reg);
                mplr_reg  <= SUM_W'(cnt_reg);
            end
        end
        if (cmd.mul_step)
        begin
            if (mplr_reg[0])
                acc_reg <= cmd.mul_sub ? acc_reg - mcand_reg : acc_reg + mcand_reg;
            mcand_reg <= mcand_reg << 1;
            mplr_reg  <= mplr_reg >> 1;
        end

        if (cmd.sqrt_load)
        begin
            rad_reg  <= (2 * ROOT_W)'(acc_reg) << (2 * FRAC_BITS);
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.sqrt_step)
        begin
            if (rem_t_c >= trial_c)
            begin
                rem_reg  <= (ROOT_W + 2)'(rem_t_c - trial_c);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= (ROOT_W + 2)'(rem_t_c);
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
            rad_reg <= rad_reg << 2;
        end

        if (cmd.div_load)
        begin
            drem_reg <= '0;
            case (cmd.div_sel)
                DSEL_MEAN:
                begin
                    dvd_reg <= DVD_W'(sum_reg) << FRAC_BITS;
                    dvs_reg <= DVS_W'(cnt_reg);
                end
                DSEL_RATE:
                begin
                    dvd_reg <= DVD_W'(cnt_reg) << FRAC_BITS;
                    dvs_reg <= DVS_W'(win_reg);
                end
                default:
                begin
                    dvd_reg <= DVD_W'(root_reg);
                    dvs_reg <= DVS_W'(cnt_reg);
                end
            endcase
        end
        if (cmd.div_step)
        begin
            drem_reg <= dge_c ? DVS_W'(drs_c - (DVS_W + 1)'(dvs_reg)) : DVS_W'(drs_c);
            dvd_reg  <= {dvd_reg[DVD_W-2:0], dge_c};
        end
        if (cmd.div_store)
        begin
            case (cmd.div_sel)
                DSEL_MEAN: mean_reg <= (|(dvd_reg >> STAT_W)) ? '1 : STAT_W'(dvd_reg);
                DSEL_RATE: rate_reg <= (|(dvd_reg >> RATE_W)) ? '1 : RATE_W'(dvd_reg);
                default:   dev_reg  <= (|(dvd_reg >> STAT_W)) ? '1 : STAT_W'(dvd_reg);
            endcase
        end

        if (cmd.out_load)
        begin
            if (cmd_reg == CMD_QUERY && win_reg == '0)
                status <= ST_ZERO_WIN;
            else if (cmd_reg == CMD_ADD && ovf_reg)
                status <= ST_OVERFLOW;
            else
                status <= ST_OK;
            marks_held      <= OCNT_W'(fill_c);
            count_in_window <= (cmd_reg == CMD_QUERY) ? OCNT_W'(cnt_reg) : '0;
            removed_count   <= (cmd_reg == CMD_CLEAN) ? OCNT_W'(cnt_reg) : '0;
            mean_bytes      <= mean_reg;
            stddev_bytes    <= dev_reg;
            ops_per_second  <= rate_reg;
        end
    end

endmodule

// ===== hw/rtl/windowed_io_stats_monitor_top.sv =====
// Top level of the windowed I/O statistics monitor: stream ports, sequencer and datapath.
// Depends on wstat_pkg, wstat_ctrl and wstat_dp.
//
//   group  dir  tdata (low bit up)                                   tuser
//   s_*    in   byte_count, now_seconds, window_seconds              command, channel
//   m_*    out  marks_held, count_in_window, removed_count,          status
//                mean_bytes, stddev_bytes, ops_per_second
//
// One command at a time; an add writes its mark, and a clean or query walks the ring mark by
// mark unless the window is zero, which skips the walk. A query with marks in the window then
// divides for mean and rate, and when two or more count it also runs the multiplier, root and
// divider for the deviation. The walk is bound by the memory read port, the rest by the
// bit-serial multiplier, root and divider. Reset clears both rings; mark memory needs no clearing.
// A held result does not block the next beat in; a stalled m_tready holds the next result.
module windowed_io_stats_monitor_top (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [79:0]  s_tdata,   // byte_count[31:0], now_seconds[63:32], window_seconds[79:64]
    input  logic [2:0]   s_tuser,   // command[1:0], channel[2]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // marks_held, count_in_window, removed_count, mean, stddev,
                                    // ops_per_second, zero pad [127:123]
    output logic [1:0]   m_tuser    // status
);
    import wstat_pkg::*;

    wstat_cmd_t        cmd;
    wstat_sts_t        sts;
    logic              idle;
    logic              in_fire;
    logic [OCNT_W-1:0] marks_held, count_in_window, removed_count;
    logic [STAT_W-1:0] mean_bytes, stddev_bytes;
    logic [RATE_W-1:0] ops_per_second;

    assign s_tready = idle;
    assign in_fire  = s_tvalid && s_tready;

    wstat_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .sts     (sts),
        .idle    (idle),
        .cmd     (cmd)
    );

    wstat_dp u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .sts               (sts),
        .in_command        (s_tuser[1:0]),
        .in_channel        (s_tuser[2]),
        .in_byte_count     (s_tdata[31:0]),
        .in_now_seconds    (s_tdata[63:32]),
        .in_window_seconds (s_tdata[79:64]),
        .out_ready         (m_tready),
        .out_valid         (m_tvalid),
        .status            (m_tuser),
        .marks_held        (marks_held),
        .count_in_window   (count_in_window),
        .removed_count     (removed_count),
        .mean_bytes        (mean_bytes),
        .stddev_bytes      (stddev_bytes),
        .ops_per_second    (ops_per_second)
    );

    assign m_tdata = {5'd0, ops_per_second, stddev_bytes, mean_bytes,
                      removed_count, count_in_window, marks_held};

    a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !s_tready)
        else $error("accepted a beat while a command was in progress");

    a_held_bound : assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (marks_held <= OCNT_W'(RING_DEPTH)) && (count_in_window <= marks_held))
        else $error("ring fill or window count out of range");

    a_overflow_full : assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_OVERFLOW) |-> (marks_held == OCNT_W'(RING_DEPTH)))
        else $error("overflow reported on a ring that is not full");

endmodule

// ===== tb/sv/windowed_io_stats_monitor_top_tb.sv =====
// Self-checking testbench for the windowed I/O statistics monitor top level.
// Drives command beats over the slave stream, predicts each result beat and checks the master
// stream against it. Depends on wstat_pkg and windowed_io_stats_monitor_top.
`timescale 1ns / 100ps

module windowed_io_stats_monitor_top_tb;
    import wstat_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  held;
        logic [8:0]  in_win;
        logic [8:0]  removed;
        logic [39:0] mean;
        logic [39:0] dev;
        logic [15:0] rate;
    } stat_res_t;

    typedef struct {
        logic [1:0]  cmd;
        logic        ch;
        logic [31:0] bytes;
        logic [31:0] now;
        logic [15:0] win;
        logic        typed;
        stat_res_t   res;
    } stim_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [79:0]  s_tdata;
    logic [2:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;

    windowed_io_stats_monitor_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // predictor state
    logic [31:0] ring_size [2][RING_DEPTH];
    logic [31:0] ring_time [2][RING_DEPTH];
    int          ring_first [2];
    int          ring_count [2];

    stat_res_t   pending_results[$];
    int          n_errors;
    int          n_checked;
    int          n_sent;
    longint      cycle_count;
    bit          calm;
    stim_row_t   rows[$];

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [31:0] mark_age(logic [31:0] t, logic [31:0] now);
        return (now >= t) ? now - t : 32'd0;
    endfunction

    function automatic logic [63:0] isqrt128(logic [127:0] x);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] sq;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            c = r | (64'd1 << b);
            sq = 128'(c) * 128'(c);
            if (sq <= x)
                r = c;
        end
        return r;
    endfunction

    // Advance the predicted rings by one command and return the result it yields.
    function automatic stat_res_t apply_command(logic [1:0] cmd, logic ch, logic [31:0] bytes,
                                                logic [31:0] now, logic [15:0] win);
        stat_res_t    r;
        int           n;
        int           k;
        int           slot;
        logic [127:0] sum;
        logic [127:0] sq;
        logic [127:0] d;
        logic [127:0] q;
        r = '0;
        n = 0;
        sum = '0;
        sq = '0;
        if (cmd == CMD_ADD)
        begin
            if (ring_count[ch] == RING_DEPTH)
            begin
                ring_first[ch] = (ring_first[ch] + 1) % RING_DEPTH;
                ring_count[ch]--;
                r.status = ST_OVERFLOW;
            end
            slot = (ring_first[ch] + ring_count[ch]) % RING_DEPTH;
            ring_size[ch][slot] = bytes;
            ring_time[ch][slot] = now;
            ring_count[ch]++;
        end
        else if (cmd == CMD_CLEAN)
        begin
            if (win == 0)
                n = ring_count[ch];
            else
                while (n < ring_count[ch])
                begin
                    slot = (ring_first[ch] + n) % RING_DEPTH;
                    if (mark_age(ring_time[ch][slot], now) < win)
                        break;
                    n++;
                end
            ring_first[ch] = (ring_first[ch] + n) % RING_DEPTH;
            ring_count[ch] -= n;
            r.removed = 9'(n);
        end
        else if (cmd == CMD_QUERY)
        begin
            if (win == 0)
                r.status = ST_ZERO_WIN;
            else
            begin
                k = ring_count[ch];
                while (k > 0)
                begin
                    slot = (ring_first[ch] + k - 1) % RING_DEPTH;
                    if (mark_age(ring_time[ch][slot], now) > win)
                        break;
                    sum += ring_size[ch][slot];
                    sq += 128'(ring_size[ch][slot]) * 128'(ring_size[ch][slot]);
                    n++;
                    k--;
                end
                if (n > 0)
                begin
                    q = (sum << FRAC_BITS) / n;
                    r.mean = (q > 128'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : q[39:0];
                    q = (128'(n) << FRAC_BITS) / win;
                    r.rate = (q > 128'hFFFF) ? 16'hFFFF : q[15:0];
                    if (n > 1)
                    begin
                        d = ((sq * n) - (sum * sum)) << (2 * FRAC_BITS);
                        q = 128'(isqrt128(d)) / n;
                        r.dev = (q > 128'hFF_FFFF_FFFF) ? 40'hFF_FFFF_FFFF : q[39:0];
                    end
                end
                r.in_win = 9'(n);
            end
        end
        r.held = 9'(ring_count[ch]);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        n_errors++;
        $display("mismatch at beat %0d: %s got %0h want %0h", n_checked, what, got, want);
    endtask

    task automatic check_result(stat_res_t got);
        stat_res_t want;
        if (pending_results.size() == 0)
        begin
            report_mismatch("result beat with nothing outstanding", 64'd1, 64'd0);
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.held !== want.held) report_mismatch("marks_held", got.held, want.held);
        if (got.in_win !== want.in_win)
            report_mismatch("count_in_window", got.in_win, want.in_win);
        if (got.removed !== want.removed)
            report_mismatch("removed_count", got.removed, want.removed);
        if (got.mean !== want.mean) report_mismatch("mean_bytes", got.mean, want.mean);
        if (got.dev !== want.dev) report_mismatch("stddev_bytes", got.dev, want.dev);
        if (got.rate !== want.rate) report_mismatch("ops_per_second", got.rate, want.rate);
        n_checked++;
    endtask

    // result side: random stall bursts, none once calm
    initial
    begin
        int burst;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                check_result(stat_res_t'({m_tuser, m_tdata[8:0], m_tdata[17:9],
                                          m_tdata[26:18], m_tdata[66:27], m_tdata[106:67],
                                          m_tdata[122:107]}));
            if (burst > 0)
            begin
                burst--;
                m_tready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                burst = $urandom_range(1, 18) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 64'd3_000_000)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("windowed_io_stats_monitor_top_tb: done, errors");
            $finish;
        end
    end

    task automatic push_row(logic [1:0] cmd, logic ch, logic [31:0] bytes, logic [31:0] now,
                            logic [15:0] win);
        stim_row_t row;
        row.cmd = cmd;
        row.ch = ch;
        row.bytes = bytes;
        row.now = now;
        row.win = win;
        row.typed = 1'b0;
        row.res = '0;
        rows = {rows, row};
    endtask

    task automatic push_typed(logic [1:0] cmd, logic ch, logic [31:0] bytes, logic [31:0] now,
                              logic [15:0] win, stat_res_t res);
        push_row(cmd, ch, bytes, now, win);
        rows[$].typed = 1'b1;
        rows[$].res = res;
    endtask

    // Send one beat, holding tvalid until accepted; random gaps before it unless calm.
    task automatic send_beat(stim_row_t row);
        stat_res_t pred;
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {row.win, row.now, row.bytes};
        s_tuser <= {row.ch, row.cmd};
        do
            @(posedge clk);
        while (!s_tready);
        pred = apply_command(row.cmd, row.ch, row.bytes, row.now, row.win);
        if (row.typed && pred !== row.res)
            report_mismatch("typed row against predictor", pred[63:0], row.res[63:0]);
        pending_results = {pending_results, (row.typed ? row.res : pred)};
        n_sent++;
    endtask

    initial
    begin
        stim_row_t   row;
        logic [31:0] t [2];
        int          ch;
        int          pick;
        n_errors = 0;
        n_checked = 0;
        n_sent = 0;
        cycle_count = 0;
        calm = 1'b0;
        ring_first = '{0, 0};
        ring_count = '{0, 0};
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows: empty rings, extremes, zero window, unused code, future marks
        push_typed(CMD_QUERY, 0, 0, 0, 0, '{ST_ZERO_WIN, 0, 0, 0, 0, 0, 0});
        push_typed(CMD_QUERY, 1, 0, 100, 16'hFFFF, '0);
        push_typed(CMD_CLEAN, 0, 0, 32'hFFFF_FFFF, 1, '0);
        push_typed(CMD_UNUSED, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, '0);
        push_typed(CMD_ADD, 0, 32'hFFFF_FFFF, 1000, 0, '{ST_OK, 1, 0, 0, 0, 0, 0});
        push_typed(CMD_ADD, 0, 32'hFFFF_FFFF, 1001, 16'hFFFF, '{ST_OK, 2, 0, 0, 0, 0, 0});
        push_row(CMD_ADD, 0, 0, 1002, 5);
        push_row(CMD_ADD, 0, 7, 5000, 5);
        push_row(CMD_QUERY, 0, 0, 1003, 16'hFFFF);
        push_row(CMD_QUERY, 0, 0, 1003, 1);
        push_row(CMD_QUERY, 0, 0, 32'hFFFF_FFFF, 16'hFFFF);
        push_row(CMD_UNUSED, 0, 0, 0, 0);
        push_row(CMD_CLEAN, 0, 0, 1003, 2);
        push_row(CMD_CLEAN, 0, 0, 1003, 16'hFFFF);
        push_row(CMD_ADD, 1, 32'h8000_0000, 32'hFFFF_FFFF, 1);
        push_row(CMD_ADD, 1, 32'h5555_5555, 32'hFFFF_FFFF, 1);
        push_row(CMD_QUERY, 1, 0, 32'hFFFF_FFFF, 1);
        push_row(CMD_CLEAN, 1, 0, 0, 0);
        push_row(CMD_CLEAN, 0, 0, 0, 0);
        foreach (rows[i]) send_beat(rows[i]);

        // overflow the channel 0 ring with random sizes
        for (int i = 0; i < RING_DEPTH + 3; i++)
        begin
            push_row(CMD_ADD, 1'b0, $urandom, 32'd100 + i, 16'($urandom));
            send_beat(rows[$]);
        end
        push_row(CMD_QUERY, 0, 0, 32'd400, 16'hFFFF);
        send_beat(rows[$]);
        push_row(CMD_QUERY, 0, 0, 32'd358, 16'd1);
        send_beat(rows[$]);

        // random part: mostly adds with rising time, some queries and cleans, rare unused codes
        t = '{32'd1000, 32'd1000};
        for (int i = 0; i < 120; i++)
        begin
            if (i == 100)
                calm = 1'b1;
            ch = $urandom_range(0, 1);
            pick = $urandom_range(0, 19);
            if ($urandom_range(0, 2) == 0)
                t[ch] += $urandom_range(0, 40);
            row.ch = 1'(ch);
            row.now = ($urandom_range(0, 49) == 0) ? $urandom : t[ch];
            row.bytes = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4096);
            row.win = ($urandom_range(0, 9) == 0) ? 16'($urandom) :
                      16'($urandom_range(0, 120));
            row.typed = 1'b0;
            row.res = '0;
            if (pick < 12)
                row.cmd = CMD_ADD;
            else if (pick < 16)
                row.cmd = CMD_QUERY;
            else if (pick < 19)
                row.cmd = CMD_CLEAN;
            else
                row.cmd = CMD_UNUSED;
            send_beat(row);
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
        $display("sent %0d command beats, checked %0d result beats", n_sent, n_checked);
        $display("covered adds with ring overflow, windowed cleans and queries on both rings");
        if (n_errors == 0)
            $display("windowed_io_stats_monitor_top_tb: done, clean");
        else
            $display("windowed_io_stats_monitor_top_tb: done, errors");
        $finish;
    end

endmodule
